// ===== sv/box_blur_3x3_rgb_assert.svh =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb assertion macros
// shared concurrent assertion forms, reset-qualified, error report only
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_ASSERT_SVH

// same-cycle implication
`define BBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbr assertion failed");

// next-cycle implication
`define BBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbr assertion failed");

`endif

// ===== sv/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg
// types, constants and helper functions of the 3x3 rgb box blur
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W  = 11;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int PIX_W  = 24;

    localparam int CSUM_W   = 10;
    localparam int SUM_W    = 12;
    localparam int SUM_MAX  = 9 * 255;
    localparam int RECIP9   = 7282;
    localparam int RECIP_W  = 13;
    localparam int RECIP_SH = 16;
    localparam int PROD_W   = SUM_W + RECIP_W;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1024);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int  REG_SEL_BIT     = 2;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_col;

    typedef struct packed {
        logic [CSUM_W-1:0] r;
        logic [CSUM_W-1:0] g;
        logic [CSUM_W-1:0] b;
    } t_csum;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_sum;

    typedef struct packed {
        logic             emit;
        logic             redge;
        logic             top_ok;
        logic             use_c1;
        logic             last;
        logic [COL_W-1:0] addr;
        t_rgb             px;
    } t_ctrl;

    function automatic logic [W_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [W_W-1:0] res;
        if (v == '0) begin
            res = W_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            res = W_W'(MAX_WIDTH);
        end else begin
            res = W_W'(v);
        end
        return res;
    endfunction

    function automatic logic [H_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
        logic [H_W-1:0] res;
        if (v == '0) begin
            res = H_W'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            res = H_W'(MAX_HEIGHT);
        end else begin
            res = H_W'(v);
        end
        return res;
    endfunction

    function automatic t_csum col_sum(input t_col c, input logic top_ok);
        t_csum s;
        s.r = CSUM_W'(c.mid.r) + CSUM_W'(c.bot.r) + (top_ok ? CSUM_W'(c.top.r) : '0);
        s.g = CSUM_W'(c.mid.g) + CSUM_W'(c.bot.g) + (top_ok ? CSUM_W'(c.top.g) : '0);
        s.b = CSUM_W'(c.mid.b) + CSUM_W'(c.bot.b) + (top_ok ? CSUM_W'(c.top.b) : '0);
        return s;
    endfunction

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RECIP9);
        return p[RECIP_SH+7:RECIP_SH];
    endfunction

endpackage

// ===== sv/bbr_ram.sv =====
// ----------------------------------------------------------------------------
// bbr_ram
// generic single write, single read ram with registered, enabled read
// ----------------------------------------------------------------------------
module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bbr_cell.sv =====
// ----------------------------------------------------------------------------
// bbr_cell
// one window column cell: holds three pixels, passes them on at each shift
// ----------------------------------------------------------------------------
module bbr_cell (
    input  logic          i_clk,
    input  logic          i_load,
    input  bbr_pkg::t_col i_col,
    input  logic          i_top_ok,
    output bbr_pkg::t_col o_col,
    output bbr_pkg::t_csum o_sum
);

    bbr_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
    assign o_sum = bbr_pkg::col_sum(r_col, i_top_ok);

endmodule

// ===== sv/bbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbr_ctrl
// input raster position, edge masks and end of frame detection
// ----------------------------------------------------------------------------
module bbr_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_fire,
    input  bbr_pkg::t_pix_in          i_item,
    input  logic [bbr_pkg::W_W-1:0]   i_width,
    input  logic [bbr_pkg::H_W-1:0]   i_height,
    output logic                      o_keep,
    output bbr_pkg::t_ctrl            o_ctrl
);

    logic [bbr_pkg::COL_W-1:0] r_col, n_col;
    logic [bbr_pkg::ROW_W-1:0] r_row, n_row;
    logic [bbr_pkg::COL_W:0]   col_inc;
    logic                      tail;
    logic                      redge;
    logic                      intr;

    always_comb begin
        tail  = r_row >= bbr_pkg::ROW_W'(i_height);
        redge = (r_col == '0) && (r_row >= bbr_pkg::ROW_W'(2));
        intr  = (r_col != '0) && (r_row != '0);

        o_keep = !((i_item.opcode == bbr_pkg::OP_FLUSH) && !tail);

        o_ctrl.emit   = redge || intr;
        o_ctrl.redge  = redge;
        o_ctrl.top_ok = redge ? (r_row >= bbr_pkg::ROW_W'(3)) : (r_row >= bbr_pkg::ROW_W'(2));
        o_ctrl.use_c1 = redge ? (i_width >= bbr_pkg::W_W'(2))
                              : (r_col >= bbr_pkg::COL_W'(2));
        o_ctrl.last   = redge &&
                        (r_row == bbr_pkg::ROW_W'(i_height) + bbr_pkg::ROW_W'(1));
        o_ctrl.addr   = r_col;
        o_ctrl.px.r   = tail ? 8'd0 : i_item.red_in;
        o_ctrl.px.g   = tail ? 8'd0 : i_item.green_in;
        o_ctrl.px.b   = tail ? 8'd0 : i_item.blue_in;

        col_inc = {1'b0, r_col} + (bbr_pkg::COL_W + 1)'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end else if (i_fire && o_keep) begin
            if (o_ctrl.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= (bbr_pkg::COL_W + 1)'(i_width)) begin
                n_col = '0;
                n_row = r_row + bbr_pkg::ROW_W'(1);
            end else begin
                n_col = col_inc[bbr_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== sv/box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// streaming 3x3 box blur over an rgb frame in raster order
// ----------------------------------------------------------------------------
// input channel: valid/ready, one pixel or flush item per accepted item.
// output channel: valid/ready, one blurred pixel per result, frame_last on
// the final pixel of the frame. each result is the per-channel sum of the
// in-frame neighbors divided by nine, truncated.
// the result for a pixel is caused by the input one row and one pixel later;
// that item then passes stage 1, stage 2 and the output register in turn.
// throughput is one item per cycle while the receiver keeps up; the line stores are read once and
// written once per item, and a two-cell window chain shifts once per item.
// after the last pixel of a frame, frame_width + 1 flush items drain the tail.
// apb port: frame_width at 0x0, frame_height at 0x4; a write restarts the
// frame. reset sets both to 1024 and clears all position counters; line
// stores need no clearing, rows above the frame are masked.
// when the receiver stalls, the output register and two internal stages
// keep taking items until full, then ready drops.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_assert.svh"

module box_blur_3x3_rgb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbr_pkg::ADDR_W-1:0]   paddr,
    input  logic [bbr_pkg::DATA_W-1:0]   pwdata,
    output logic [bbr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bbr_pkg::t_pix_in             i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bbr_pkg::t_pix_out            o_out_item
);

    logic [bbr_pkg::CFG_W-1:0] r_frame_width;
    logic [bbr_pkg::CFG_W-1:0] r_frame_height;
    logic                      cfg_wr;
    logic [bbr_pkg::W_W-1:0]   width;
    logic [bbr_pkg::H_W-1:0]   height;

    logic                      fire;
    logic                      keep;
    bbr_pkg::t_ctrl            ctrl;

    logic                      r_s1_v;
    bbr_pkg::t_ctrl            r_s1_ctrl;
    logic                      r_byp_v;
    bbr_pkg::t_rgb             r_byp_d;
    bbr_pkg::t_rgb             up_rd;
    bbr_pkg::t_rgb             mid_rd;
    bbr_pkg::t_col             new_col;
    bbr_pkg::t_col             c0_col;
    bbr_pkg::t_csum            c0_sum;
    bbr_pkg::t_csum            c1_sum;
    bbr_pkg::t_csum            new_sum;
    bbr_pkg::t_sum             sum;

    logic                      r_s2_v;
    bbr_pkg::t_sum             r_s2_sum;
    logic                      r_s2_last;

    logic                      r_out_v;
    bbr_pkg::t_pix_out         r_out_item;

    logic                      out_free;
    logic                      s2_free;
    logic                      s2_move;
    logic                      s1_move;
    logic                      sum_ok;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bbr_pkg::DIM_RESET;
            r_frame_height <= bbr_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[bbr_pkg::REG_SEL_BIT])
                bbr_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[bbr_pkg::CFG_W-1:0];
                bbr_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[bbr_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[bbr_pkg::REG_SEL_BIT])
            bbr_pkg::REG_FRAME_WIDTH:  prdata = bbr_pkg::DATA_W'(r_frame_width);
            bbr_pkg::REG_FRAME_HEIGHT: prdata = bbr_pkg::DATA_W'(r_frame_height);
            default:                   prdata = '0;
        endcase
    end

    assign width  = bbr_pkg::clamp_width(r_frame_width);
    assign height = bbr_pkg::clamp_height(r_frame_height);

    // flow control
    assign out_free   = !r_out_v || i_out_ready;
    assign s2_free    = !r_s2_v || out_free;
    assign s2_move    = r_s2_v && out_free;
    assign s1_move    = r_s1_v && (!r_s1_ctrl.emit || s2_free);
    assign o_in_ready = !r_s1_v || s1_move;
    assign fire       = i_in_valid && o_in_ready;

    bbr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_wr),
        .i_fire   (fire),
        .i_item   (i_in_item),
        .i_width  (width),
        .i_height (height),
        .o_keep   (keep),
        .o_ctrl   (ctrl)
    );

    // line stores
    bbr_ram #(
        .WIDTH (bbr_pkg::PIX_W),
        .DEPTH (bbr_pkg::MAX_WIDTH)
    ) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (fire && keep),
        .i_waddr (ctrl.addr),
        .i_wdata (ctrl.px),
        .i_re    (fire && keep),
        .i_raddr (ctrl.addr),
        .o_rdata (mid_rd)
    );

    bbr_ram #(
        .WIDTH (bbr_pkg::PIX_W),
        .DEPTH (bbr_pkg::MAX_WIDTH)
    ) u_up_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_ctrl.addr),
        .i_wdata (mid_rd),
        .i_re    (fire && keep),
        .i_raddr (ctrl.addr),
        .o_rdata (up_rd)
    );

    // stage 1: item with line store data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (fire && keep) begin
            r_s1_v <= 1'b1;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    // forward the upper store write that lands in the same cycle as the read
    always_ff @(posedge i_clk) begin
        if (fire && keep) begin
            r_s1_ctrl <= ctrl;
            r_byp_v   <= s1_move && (r_s1_ctrl.addr == ctrl.addr);
            r_byp_d   <= mid_rd;
        end
    end

    assign new_col.top = r_byp_v ? r_byp_d : up_rd;
    assign new_col.mid = mid_rd;
    assign new_col.bot = r_s1_ctrl.px;
    assign new_sum     = bbr_pkg::col_sum(new_col, r_s1_ctrl.top_ok);

    // window chain
    bbr_cell u_cell0 (
        .i_clk    (i_clk),
        .i_load   (s1_move),
        .i_col    (new_col),
        .i_top_ok (r_s1_ctrl.top_ok),
        .o_col    (c0_col),
        .o_sum    (c0_sum)
    );

    bbr_cell u_cell1 (
        .i_clk    (i_clk),
        .i_load   (s1_move),
        .i_col    (c0_col),
        .i_top_ok (r_s1_ctrl.top_ok),
        .o_col    (),
        .o_sum    (c1_sum)
    );

    always_comb begin
        sum.r = bbr_pkg::SUM_W'(c0_sum.r)
              + (r_s1_ctrl.use_c1 ? bbr_pkg::SUM_W'(c1_sum.r) : '0)
              + (r_s1_ctrl.redge ? '0 : bbr_pkg::SUM_W'(new_sum.r));
        sum.g = bbr_pkg::SUM_W'(c0_sum.g)
              + (r_s1_ctrl.use_c1 ? bbr_pkg::SUM_W'(c1_sum.g) : '0)
              + (r_s1_ctrl.redge ? '0 : bbr_pkg::SUM_W'(new_sum.g));
        sum.b = bbr_pkg::SUM_W'(c0_sum.b)
              + (r_s1_ctrl.use_c1 ? bbr_pkg::SUM_W'(c1_sum.b) : '0)
              + (r_s1_ctrl.redge ? '0 : bbr_pkg::SUM_W'(new_sum.b));
    end

    // stage 2: window sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_move && r_s1_ctrl.emit) begin
            r_s2_v <= 1'b1;
        end else if (s2_move) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_ctrl.emit) begin
            r_s2_sum  <= sum;
            r_s2_last <= r_s1_ctrl.last;
        end
    end

    // output register: divide by nine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s2_move) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_item.red_out    <= bbr_pkg::div9(r_s2_sum.r);
            r_out_item.green_out  <= bbr_pkg::div9(r_s2_sum.g);
            r_out_item.blue_out   <= bbr_pkg::div9(r_s2_sum.b);
            r_out_item.frame_last <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out_item;

    assign sum_ok = (r_s2_sum.r <= bbr_pkg::SUM_W'(bbr_pkg::SUM_MAX))
                 && (r_s2_sum.g <= bbr_pkg::SUM_W'(bbr_pkg::SUM_MAX))
                 && (r_s2_sum.b <= bbr_pkg::SUM_W'(bbr_pkg::SUM_MAX));

    `BBR_ASSERT_NXT(a_keep_loads_s1, i_clk, i_rst_n, fire && keep, r_s1_v)
    `BBR_ASSERT_IMP(a_last_emits, i_clk, i_rst_n, r_s1_v && r_s1_ctrl.last, r_s1_ctrl.emit)
    `BBR_ASSERT_NXT(a_s2_holds, i_clk, i_rst_n, r_s2_v && !out_free, r_s2_v && $stable(r_s2_sum))
    `BBR_ASSERT_IMP(a_sum_range, i_clk, i_rst_n, r_s2_v, sum_ok)

endmodule
